// ----- rtl/ipv4p_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv4 text address parser package
// Shared parse state type, decision codes, phase codes and character codes.
// ----------------------------------------------------------------------------
package ipv4p_pkg;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_NUL   = 8'h00;

    localparam logic [9:0] OCTET_MAX    = 10'd255;
    localparam logic [2:0] OCTET_DIGITS = 3'd3;
    localparam logic [2:0] PORT_DIGITS  = 3'd5;

    localparam logic [2:0] PH_OCTET0     = 3'd0;
    localparam logic [2:0] PH_OCTET1     = 3'd1;
    localparam logic [2:0] PH_OCTET2     = 3'd2;
    localparam logic [2:0] PH_LAST_OCTET = 3'd3;
    localparam logic [2:0] PH_PORT       = 3'd5;
    localparam logic [2:0] PH_DONE       = 3'd6;

    localparam logic [1:0] DEC_CONT         = 2'd0;
    localparam logic [1:0] DEC_ACCEPT       = 2'd1;
    localparam logic [1:0] DEC_FAIL         = 2'd2;
    localparam logic [1:0] DEC_FAIL_MISSING = 2'd3;

    typedef struct packed {
        logic [2:0]  phase;
        logic [2:0]  digit_count;
        logic [9:0]  octet_value;
        logic [31:0] address_acc;
        logic [4:0]  consumed_len;
    } parse_state_t;

    localparam parse_state_t STATE_RESET = '0;

endpackage

// ----- rtl/ipv4p_feed.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv4 parser character step
// Advances the parse state by one character and reports the decision code.
// ----------------------------------------------------------------------------
module ipv4p_feed
(
    input  ipv4p_pkg::parse_state_t st,
    input  logic [7:0]              ch,
    output ipv4p_pkg::parse_state_t st_next,
    output logic [1:0]              dec
);

    logic        dig;
    logic [3:0]  dval;
    logic [9:0]  mac;
    logic [31:0] placed;

    assign dig  = (ch >= ipv4p_pkg::CH_ZERO) && (ch <= ipv4p_pkg::CH_NINE);
    assign dval = 4'(ch - ipv4p_pkg::CH_ZERO);
    assign mac  = 10'(st.octet_value * 10'd10) + {6'd0, dval};

    always_comb
    begin
        case (st.phase)
            ipv4p_pkg::PH_OCTET0: placed = {st.octet_value[7:0], 24'd0};
            ipv4p_pkg::PH_OCTET1: placed = {8'd0, st.octet_value[7:0], 16'd0};
            ipv4p_pkg::PH_OCTET2: placed = {16'd0, st.octet_value[7:0], 8'd0};
            default:              placed = {24'd0, st.octet_value[7:0]};
        endcase
    end

    always_comb
    begin
        st_next = st;
        dec     = ipv4p_pkg::DEC_CONT;
        if (st.phase < ipv4p_pkg::PH_LAST_OCTET)
        begin
            if (dig && (st.digit_count < ipv4p_pkg::OCTET_DIGITS))
            begin
                st_next.octet_value  = mac;
                st_next.digit_count  = st.digit_count + 3'd1;
                st_next.consumed_len = st.consumed_len + 5'd1;
            end
            else if (st.digit_count == 3'd0)
            begin
                dec = ipv4p_pkg::DEC_FAIL_MISSING;
            end
            else if ((ch != ipv4p_pkg::CH_DOT) || (st.octet_value > ipv4p_pkg::OCTET_MAX))
            begin
                dec = ipv4p_pkg::DEC_FAIL;
            end
            else
            begin
                st_next.address_acc  = st.address_acc | placed;
                st_next.phase        = st.phase + 3'd1;
                st_next.digit_count  = 3'd0;
                st_next.octet_value  = 10'd0;
                st_next.consumed_len = st.consumed_len + 5'd1;
            end
        end
        else if (st.phase == ipv4p_pkg::PH_LAST_OCTET)
        begin
            if (dig && (st.digit_count < ipv4p_pkg::OCTET_DIGITS))
            begin
                st_next.octet_value  = mac;
                st_next.digit_count  = st.digit_count + 3'd1;
                st_next.consumed_len = st.consumed_len + 5'd1;
            end
            else if ((st.digit_count == 3'd0) || (st.octet_value > ipv4p_pkg::OCTET_MAX))
            begin
                dec = ipv4p_pkg::DEC_FAIL;
            end
            else
            begin
                st_next.address_acc = st.address_acc | placed;
                if (ch == ipv4p_pkg::CH_COLON)
                begin
                    st_next.phase        = ipv4p_pkg::PH_PORT;
                    st_next.digit_count  = 3'd0;
                    st_next.consumed_len = st.consumed_len + 5'd1;
                end
                else
                begin
                    dec = ipv4p_pkg::DEC_ACCEPT;
                end
            end
        end
        else if (st.phase == ipv4p_pkg::PH_PORT)
        begin
            if (dig && (st.digit_count < ipv4p_pkg::PORT_DIGITS))
            begin
                st_next.digit_count  = st.digit_count + 3'd1;
                st_next.consumed_len = st.consumed_len + 5'd1;
            end
            else if (st.digit_count == 3'd0)
            begin
                dec = ipv4p_pkg::DEC_FAIL;
            end
            else
            begin
                dec = ipv4p_pkg::DEC_ACCEPT;
            end
        end
    end

endmodule

// ----- rtl/ipv4_text_address_parser_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv4 text address parser
// Parses dotted-decimal IPv4 addresses with an optional port from a stream of
// characters and reports one result per candidate string.
//
// Characters arrive on the char channel (ch, last); a transfer takes place
// when char_valid is high and char_stall is low. The character with last set
// closes the candidate string, which is treated as followed by a NUL.
// Results leave on the res channel (accepted, missing_digit, address, length)
// with the same valid and stall rules; at most one result is given per string,
// at the character where the decision falls, and later characters up to the
// end mark give none.
// A character sits in an input register while the parse state and the
// result register are updated from it, and the result is offered from the
// result register. One character is taken every cycle while char_stall is low.
// When res_stall holds a waiting result, a character that would produce
// another result is held and char_stall is raised; characters that produce
// no result keep flowing. Reset empties both registers and clears the parse
// state to the start of the first octet.
// ----------------------------------------------------------------------------
module ipv4_text_address_parser_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        char_valid,
    output logic        char_stall,
    input  logic [7:0]  ch,
    input  logic        last,
    output logic        res_valid,
    input  logic        res_stall,
    output logic        accepted,
    output logic        missing_digit,
    output logic [31:0] address,
    output logic [4:0]  length
);

    logic                    in_valid_reg;
    logic [7:0]              ch_reg;
    logic                    last_reg;
    ipv4p_pkg::parse_state_t st_reg;
    ipv4p_pkg::parse_state_t st_next;
    ipv4p_pkg::parse_state_t st_a;
    ipv4p_pkg::parse_state_t st_one;
    ipv4p_pkg::parse_state_t st_b;
    logic [1:0]              dec_a;
    logic [1:0]              dec_b;
    logic [1:0]              dec_fin;
    ipv4p_pkg::parse_state_t st_emit;
    logic                    produce;
    logic                    advance;
    logic                    consume;

    logic                    res_valid_reg;
    logic                    accepted_reg;
    logic                    missing_reg;
    logic [31:0]             address_reg;
    logic [4:0]              length_reg;

    ipv4p_feed u_feed_char
    (
        .st      (st_reg),
        .ch      (ch_reg),
        .st_next (st_a),
        .dec     (dec_a)
    );

    always_comb
    begin
        st_one = st_a;
        if (dec_a != ipv4p_pkg::DEC_CONT)
        begin
            st_one.phase = ipv4p_pkg::PH_DONE;
        end
    end

    ipv4p_feed u_feed_end
    (
        .st      (st_one),
        .ch      (ipv4p_pkg::CH_NUL),
        .st_next (st_b),
        .dec     (dec_b)
    );

    always_comb
    begin
        produce = 1'b0;
        dec_fin = dec_a;
        st_emit = st_a;
        if (dec_a != ipv4p_pkg::DEC_CONT)
        begin
            produce = 1'b1;
        end
        else if (last_reg && (st_one.phase != ipv4p_pkg::PH_DONE))
        begin
            produce = 1'b1;
            st_emit = st_b;
            dec_fin = (dec_b == ipv4p_pkg::DEC_CONT) ? ipv4p_pkg::DEC_FAIL : dec_b;
        end
        st_next = last_reg ? ipv4p_pkg::STATE_RESET : st_one;
    end

    assign advance    = !produce || !res_valid_reg || !res_stall;
    assign consume    = in_valid_reg && advance;
    assign char_stall = in_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            st_reg        <= ipv4p_pkg::STATE_RESET;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (!char_stall)
            begin
                in_valid_reg <= char_valid;
            end
            if (consume)
            begin
                st_reg <= st_next;
            end
            if (consume && produce)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!char_stall)
        begin
            ch_reg   <= ch;
            last_reg <= last;
        end
        if (consume && produce)
        begin
            accepted_reg <= (dec_fin == ipv4p_pkg::DEC_ACCEPT);
            missing_reg  <= (dec_fin == ipv4p_pkg::DEC_FAIL_MISSING);
            address_reg  <= (dec_fin == ipv4p_pkg::DEC_ACCEPT) ? st_emit.address_acc : 32'd0;
            length_reg   <= (dec_fin == ipv4p_pkg::DEC_ACCEPT) ? st_emit.consumed_len : 5'd0;
        end
    end

    assign res_valid     = res_valid_reg;
    assign accepted      = accepted_reg;
    assign missing_digit = missing_reg;
    assign address       = address_reg;
    assign length        = length_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        char_stall |-> (res_valid && res_stall))
        else $error("char_stall raised while the result register could move");

    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !accepted) |-> ((address == 32'd0) && (length == 5'd0)))
        else $error("failed result carries a non-zero address or length");

    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && accepted) |-> !missing_digit)
        else $error("accepted result flags a missing digit");

    assert property (@(posedge clk) disable iff (!rst_n)
        (consume && last_reg) |=> (st_reg == ipv4p_pkg::STATE_RESET))
        else $error("parse state not cleared after the end of a string");

endmodule
